[src/peq_pkg.sv]
// Package: payload types and operation codes for the prioritized event queue.
package peq_pkg;

    typedef enum logic [3:0] {
        MODE_SIGNAL     = 4'd0,
        MODE_CALL       = 4'd1,
        MODE_COMPLETE   = 4'd2,
        MODE_UNCOMPLETE = 4'd3,
        MODE_FETCH      = 4'd4,
        MODE_DEFER      = 4'd5,
        MODE_CHOOSE     = 4'd6,
        MODE_QUERY      = 4'd7,
        MODE_ACK        = 4'd8
    } mode_t;

    localparam logic [1:0] KIND_SIGNAL     = 2'd0;
    localparam logic [1:0] KIND_COMPLETION = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NO_CUR  = 2'd3;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] event_id;
        logic [1:0] event_kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_id;
        logic [1:0] out_kind;
        logic       is_contained;
        logic       is_completed;
        logic       matches_current;
    } rsp_t;

endpackage

[src/prioritized_event_queue.sv]
// Top level: event dispatcher with internal stack, external and deferred queues.
//
// One command word per start; busy is high while it runs and drops
// in the cycle that carries the done strobe, so the next word can be taken there.
// Signal, call, defer, choose, acknowledge, an unused mode and a query of a
// non-completion kind pass only the read and response states; a fetch from a
// queue, or with nothing to fetch, also passes the fetch state. A fetch from the
// stack shifts the rest up, reading and then writing each entry. Complete shifts
// the stack down, one entry per cycle through the stack RAM, unless it is full.
// Uncomplete and a completion query scan the stack, reading then comparing each
// entry, and an uncomplete hit then shifts the remainder up.
// The completed bitmap lives in a RAM that is swept clear after reset, with busy
// high during the sweep. The response strobe (done) is high one cycle; the
// receiver cannot hold it off.
module prioritized_event_queue
    import peq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_COUNT    = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = $clog2(ID_COUNT);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_FETCH, S_DEFER, S_PUSH, S_SCAN, S_SHUP,
        S_SHDN, S_BMAP, S_RESP
    } state_t;

    state_t          state_reg;
    cmd_t            cmd_reg;
    rsp_t            rsp_reg;
    logic            done_reg;
    logic [CW-1:0]   icnt_reg, ecnt_reg, dcnt_reg;
    logic [AW-1:0]   ehead_reg, dhead_reg;
    logic            cur_valid_reg, chosen_reg;
    logic [7:0]      cur_id_reg;
    logic [1:0]      cur_kind_reg;
    logic [CW-1:0]   idx_reg;
    logic [MW-1:0]   clr_reg;
    logic            hit_reg;

    // stack RAM
    logic            s_we;
    logic [AW-1:0]   s_wa, s_ra;
    logic [7:0]      s_wd, s_rd;
    // queue RAMs
    logic            e_we, d_we;
    logic [AW-1:0]   e_wa, d_wa;
    logic [9:0]      e_wd, d_wd, e_rd, d_rd;
    // bitmap RAM
    logic            m_we;
    logic [MW-1:0]   m_wa, m_ra;
    logic            m_wd, m_rd;

    peq_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    peq_ram #(.WIDTH(10), .DEPTH(QUEUE_DEPTH)) u_ext (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(ehead_reg), .rdata(e_rd));
    peq_ram #(.WIDTH(10), .DEPTH(QUEUE_DEPTH)) u_def (
        .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(dhead_reg), .rdata(d_rd));
    peq_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_map (
        .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

    logic id_in_map;
    assign id_in_map = (32'(cmd_reg.event_id) < 32'(ID_COUNT));

    logic [AW-1:0] idx_a;
    assign idx_a = idx_reg[AW-1:0];

    // stack read address: scan and shift-up read idx; complete reads count-1
    // ahead, then shift-down reads idx-3 so entry idx-2 is there when idx drops
    always_comb
    begin
        s_ra = idx_a;
        if (state_reg == S_IDLE)
        begin
            s_ra = '0;
        end
        else if (state_reg == S_RD && cmd_reg.mode == MODE_COMPLETE)
        begin
            s_ra = AW'(icnt_reg - CW'(1));
        end
        else if (state_reg == S_SHDN)
        begin
            s_ra = AW'(idx_reg - CW'(3));
        end
    end

    // the word is read from the port while idle so the bit is ready in S_RD
    assign m_ra = (state_reg == S_IDLE) ? MW'(cmd.event_id) : MW'(cmd_reg.event_id);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return AW'(s);
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    // memory writes
    always_comb
    begin
        s_we = 1'b0; s_wa = idx_a; s_wd = s_rd;
        e_we = 1'b0; e_wa = wrap_add(ehead_reg, ecnt_reg);
        e_wd = {cmd_reg.event_id, cmd_reg.mode[1:0]};
        d_we = 1'b0; d_wa = wrap_add(dhead_reg, dcnt_reg);
        d_wd = {cur_id_reg, cur_kind_reg};
        m_we = 1'b0; m_wa = MW'(cmd_reg.event_id); m_wd = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                m_we = 1'b1; m_wa = clr_reg;
            end
            S_RD:
            begin
                if ((cmd_reg.mode == MODE_SIGNAL || cmd_reg.mode == MODE_CALL)
                    && ecnt_reg < FULL)
                begin
                    e_we = 1'b1;
                end
                if (cmd_reg.mode == MODE_DEFER && cur_valid_reg && dcnt_reg < FULL)
                begin
                    d_we = 1'b1;
                end
            end
            S_SHDN:
            begin
                // idx>1 moves entry idx-2 to idx-1; idx==1 puts new id at top
                s_we = 1'b1; s_wa = AW'(idx_reg - CW'(1));
                s_wd = (idx_reg == CW'(1)) ? cmd_reg.event_id : s_rd;
            end
            S_PUSH:
            begin
                // s_rd holds entry idx, read in S_SHUP
                s_we = 1'b1; s_wa = AW'(idx_reg - CW'(1));
            end
            S_BMAP:
            begin
                m_we = id_in_map;
                m_wd = (cmd_reg.mode == MODE_COMPLETE);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmd_reg       <= '0;
            rsp_reg       <= '0;
            done_reg      <= 1'b0;
            icnt_reg      <= '0;
            ecnt_reg      <= '0;
            dcnt_reg      <= '0;
            ehead_reg     <= '0;
            dhead_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            cur_kind_reg  <= '0;
            chosen_reg    <= 1'b0;
            clr_reg       <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + MW'(1);
                    if (clr_reg == MW'(ID_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        rsp_reg   <= '0;
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RESP;
                    case (cmd_reg.mode) inside
                        MODE_SIGNAL, MODE_CALL:
                        begin
                            if (ecnt_reg < FULL)
                                ecnt_reg <= ecnt_reg + CW'(1);
                            else
                                rsp_reg.status <= ST_FULL;
                        end
                        MODE_COMPLETE:
                        begin
                            if (icnt_reg < FULL)
                            begin
                                idx_reg   <= icnt_reg + CW'(1);
                                state_reg <= S_SHDN;
                            end
                            else
                            begin
                                rsp_reg.status <= ST_FULL;
                                state_reg      <= S_BMAP;
                            end
                        end
                        MODE_UNCOMPLETE:
                            state_reg <= S_SCAN;
                        MODE_FETCH:
                            state_reg <= S_FETCH;
                        MODE_DEFER:
                        begin
                            if (!cur_valid_reg)
                                rsp_reg.status <= ST_NO_CUR;
                            else
                            begin
                                chosen_reg <= 1'b0;
                                if (dcnt_reg < FULL)
                                    dcnt_reg <= dcnt_reg + CW'(1);
                                else
                                    rsp_reg.status <= ST_FULL;
                            end
                        end
                        MODE_CHOOSE:
                            chosen_reg <= 1'b1;
                        MODE_QUERY:
                        begin
                            if (cur_valid_reg && cur_id_reg == cmd_reg.event_id
                                && cur_kind_reg == cmd_reg.event_kind)
                            begin
                                rsp_reg.matches_current <= 1'b1;
                                rsp_reg.is_contained    <= 1'b1;
                            end
                            if (!cur_valid_reg)
                                rsp_reg.status <= ST_NO_CUR;
                            if (cmd_reg.event_kind == KIND_COMPLETION)
                            begin
                                rsp_reg.is_completed <= m_rd && id_in_map;
                                state_reg <= S_SCAN;
                            end
                        end
                        MODE_ACK:
                        begin
                            if (cur_valid_reg)
                            begin
                                rsp_reg.out_id   <= cur_id_reg;
                                rsp_reg.out_kind <= cur_kind_reg;
                            end
                            else
                                rsp_reg.status <= ST_NO_CUR;
                        end
                        default: ;
                    endcase
                end
                S_FETCH:
                begin
                    // s_rd holds top of stack, e_rd/d_rd the queue heads
                    state_reg <= S_RESP;
                    if (icnt_reg != '0)
                    begin
                        cur_valid_reg <= 1'b1;
                        cur_id_reg    <= s_rd;
                        cur_kind_reg  <= KIND_COMPLETION;
                        rsp_reg.out_id   <= s_rd;
                        rsp_reg.out_kind <= KIND_COMPLETION;
                        idx_reg   <= CW'(1);
                        state_reg <= S_SHUP;
                    end
                    else if (chosen_reg && dcnt_reg != '0)
                    begin
                        cur_valid_reg <= 1'b1;
                        {cur_id_reg, cur_kind_reg} <= d_rd;
                        {rsp_reg.out_id, rsp_reg.out_kind} <= d_rd;
                        dhead_reg <= wrap_inc(dhead_reg);
                        dcnt_reg  <= dcnt_reg - CW'(1);
                    end
                    else if (ecnt_reg != '0)
                    begin
                        cur_valid_reg <= 1'b1;
                        {cur_id_reg, cur_kind_reg} <= e_rd;
                        {rsp_reg.out_id, rsp_reg.out_kind} <= e_rd;
                        ehead_reg <= wrap_inc(ehead_reg);
                        ecnt_reg  <= ecnt_reg - CW'(1);
                    end
                    else
                    begin
                        cur_valid_reg  <= 1'b0;
                        rsp_reg.status <= ST_EMPTY;
                    end
                end
                S_SCAN:
                begin
                    // reading entry idx; data arrives next cycle
                    if (hit_reg || idx_reg >= icnt_reg)
                    begin
                        state_reg <= (cmd_reg.mode == MODE_QUERY) ? S_RESP : S_BMAP;
                    end
                    else
                    begin
                        state_reg <= S_DEFER;
                    end
                end
                S_DEFER:
                begin
                    // compare read data of entry idx
                    if (s_rd == cmd_reg.event_id)
                    begin
                        if (cmd_reg.mode == MODE_QUERY)
                        begin
                            rsp_reg.is_contained <= 1'b1;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_SHUP;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SHUP:
                begin
                    // read entry idx here, move it up to idx-1 in S_PUSH
                    if (idx_reg >= icnt_reg)
                    begin
                        icnt_reg  <= icnt_reg - CW'(1);
                        state_reg <= (cmd_reg.mode == MODE_FETCH) ? S_RESP : S_BMAP;
                    end
                    else
                    begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    state_reg <= S_SHUP;
                    idx_reg   <= idx_reg + CW'(1);
                end
                S_SHDN:
                begin
                    if (idx_reg == CW'(1))
                    begin
                        icnt_reg  <= icnt_reg + CW'(1);
                        state_reg <= S_BMAP;
                    end
                    else
                    begin
                        state_reg <= S_SHDN;
                    end
                    idx_reg <= idx_reg - CW'(1);
                end
                S_BMAP:
                    state_reg <= S_RESP;
                S_RESP:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[src/peq_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module peq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
